// File: sv/gpsc_pkg.sv
`timescale 1ns / 1ps
// gpsc_pkg: shared types and constants of the gclock pinned slot cache
// fixed field widths, action, status, slot mode and sequencer state codes
// no dependencies
package gpsc_pkg;

   localparam int ACTION_W = 2;
   localparam int ID_W     = 24;
   localparam int WEIGHT_W = 8;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 3;

   // widest tag and slot index the parameters allow
   localparam int ID_WIDE   = 32;
   localparam int SLOT_WIDE = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_REQUEST = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_FILL    = 2'd2,
      ACT_CLEAR   = 2'd3
   } gpsc_action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT        = 3'd0,
      ST_MISS_FREE  = 3'd1,
      ST_MISS_EVICT = 3'd2,
      ST_BUSY       = 3'd3,
      ST_NONE       = 3'd4,
      ST_DONE       = 3'd5,
      ST_NOT_FOUND  = 3'd6
   } gpsc_status_type;

   typedef enum logic [1:0] {
      MODE_EMPTY  = 2'd0,
      MODE_ALLOC  = 2'd1,
      MODE_LOADED = 2'd2
   } gpsc_mode_type;

   typedef enum logic [2:0] {
      S_CLEAR    = 3'd0,
      S_IDLE     = 3'd1,
      S_FIND     = 3'd2,
      S_SWEEP    = 3'd3,
      S_FILL_RD  = 3'd4,
      S_FILL_CHK = 3'd5,
      S_RESP     = 3'd6
   } gpsc_state_type;

   typedef struct packed {
      gpsc_status_type     status;
      logic [INDEX_W-1:0]  slot;
      logic                slot_filled;
      logic                evicted_valid;
      logic [ID_W-1:0]     evicted_block_id;
   } gpsc_result_type;

endpackage

// File: sv/gpsc_req_if.sv
`timescale 1ns / 1ps
// gpsc_req_if: request channel of the slot cache, valid/ready plus item fields
// depends on gpsc_pkg for the field widths
interface gpsc_req_if;
   logic                             valid;
   logic                             ready;
   logic [gpsc_pkg::ACTION_W-1:0]    action;
   logic [gpsc_pkg::ID_W-1:0]        block_id;
   logic [gpsc_pkg::WEIGHT_W-1:0]    ref_weight;
   logic [gpsc_pkg::INDEX_W-1:0]     slot_index;

   modport source (output valid, action, block_id, ref_weight, slot_index, input ready);
   modport sink (input valid, action, block_id, ref_weight, slot_index, output ready);
endinterface

// File: sv/gpsc_rsp_if.sv
`timescale 1ns / 1ps
// gpsc_rsp_if: result channel of the slot cache, valid/ready plus result fields
// depends on gpsc_pkg for the field widths
interface gpsc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [gpsc_pkg::STATUS_W-1:0]    status;
   logic [gpsc_pkg::INDEX_W-1:0]     slot;
   logic                             slot_filled;
   logic                             evicted_valid;
   logic [gpsc_pkg::ID_W-1:0]        evicted_block_id;

   modport source (output valid, status, slot, slot_filled, evicted_valid, evicted_block_id,
                   input ready);
   modport sink (input valid, status, slot, slot_filled, evicted_valid, evicted_block_id,
                 output ready);
endinterface

// File: sv/gclock_pinned_slot_cache.sv
`timescale 1ns / 1ps
// gclock_pinned_slot_cache: slot table with pinning and gclock replacement
// depends on gpsc_pkg, gpsc_req_if and gpsc_rsp_if
//
// usage
//   req_chan carries one beat per action: request, release, fill or clear.
//   rsp_chan returns exactly one result beat per request beat, in order.
//   the slot table (tag, mode, pin, count per slot) sits in one memory with
//   one write and one registered read port; a small sequencer walks it.
// sequencing (one item at a time, ready only when idle)
//   request / release: the table is scanned slot by slot, one slot a cycle,
//     from slot zero up to the result beat (a hit ends the scan early)
//   miss with no empty slot: the hand sweeps one slot a cycle from the hand,
//     ageing each unpinned slot until a count reaches zero
//   fill: read of the target slot, then the tag check; clear: clearing pass, then the result
//   the single memory read port paces these steps
// reset
//   after reset a clearing pass empties the table; req ready stays low until
//   it finishes
// stall
//   a result waits in the output register; the next beat is still accepted,
//   and its result is held back until the output register is free
module gclock_pinned_slot_cache #(
   parameter int SLOTS      = 64,
   parameter int ID_BITS    = 24,
   parameter int COUNT_BITS = 8
) (
   input logic        clock,
   input logic        reset,
   gpsc_req_if.sink   req_chan,
   gpsc_rsp_if.source rsp_chan
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SUM_W  = ((COUNT_BITS > gpsc_pkg::WEIGHT_W) ?
                            COUNT_BITS : gpsc_pkg::WEIGHT_W) + 1;
   localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef logic [SLOT_W-1:0] slot_idx_type;

   typedef struct packed {
      logic [ID_BITS-1:0]       tag;
      gpsc_pkg::gpsc_mode_type  mode;
      logic                     pinned;
      logic [COUNT_BITS-1:0]    count;
   } entry_type;

   // next slot with wrap at the table end
   function automatic slot_idx_type next_slot(input slot_idx_type idx);
      return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
   endfunction

   // low bits of a slot index as reported on the result channel
   function automatic logic [gpsc_pkg::INDEX_W-1:0] slot_out(input slot_idx_type idx);
      logic [gpsc_pkg::SLOT_WIDE-1:0] wide;
      wide = gpsc_pkg::SLOT_WIDE'(idx);
      return wide[gpsc_pkg::INDEX_W-1:0];
   endfunction

   // slot table memory
   entry_type    mem [0:SLOTS-1];
   entry_type    mem_q_ff;
   logic         wr_en;
   slot_idx_type wr_addr;
   entry_type    wr_data;
   logic         rd_en;
   slot_idx_type rd_addr;

   // sequencer state
   gpsc_pkg::gpsc_state_type state_ff, state_in;
   slot_idx_type scan_ff, scan_in;
   logic         issue_done_ff, issue_done_in;
   logic         q_vld_ff;
   slot_idx_type q_idx_ff;
   slot_idx_type hand_ff, hand_in;
   logic         clr_rsp_ff, clr_rsp_in;

   // latched request
   gpsc_pkg::gpsc_action_type        act_ff, act_in;
   logic [ID_BITS-1:0]               id_ff, id_in;
   logic [gpsc_pkg::WEIGHT_W-1:0]    w_ff, w_in;
   logic [gpsc_pkg::INDEX_W-1:0]     si_ff, si_in;

   // scan bookkeeping: first empty at/after hand, first empty overall, any unpinned
   logic         ge_found_ff, ge_found_in;
   slot_idx_type ge_idx_ff, ge_idx_in;
   logic         any_found_ff, any_found_in;
   slot_idx_type any_idx_ff, any_idx_in;
   logic         unpinned_ff, unpinned_in;

   // pending result and output register
   gpsc_pkg::gpsc_result_type res_ff, res_in;
   gpsc_pkg::gpsc_result_type out_ff, out_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // datapath helpers
   logic [gpsc_pkg::ID_WIDE-1:0]   req_id_wide;
   logic [gpsc_pkg::ID_WIDE-1:0]   tag_wide;
   logic [gpsc_pkg::SLOT_WIDE-1:0] si_wide;
   logic                           si_ok;
   slot_idx_type                   si_addr;
   logic [SUM_W-1:0]               hit_sum;
   logic [SUM_W-1:0]               w_sum;
   logic [COUNT_BITS-1:0]          hit_count;
   logic [COUNT_BITS-1:0]          new_count;
   logic [COUNT_BITS-1:0]          dec_count;
   entry_type                      new_entry;
   logic                           cur_match;
   logic                           cur_empty;
   logic                           ge_now;
   slot_idx_type                   ge_idx_now;
   logic                           any_now;
   slot_idx_type                   any_idx_now;
   logic                           unpinned_now;
   slot_idx_type                   chosen;
   logic                           accept;

   assign req_chan.ready = (state_ff == gpsc_pkg::S_IDLE);
   assign accept         = req_chan.valid && (state_ff == gpsc_pkg::S_IDLE);

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = out_ff.status;
   assign rsp_chan.slot             = out_ff.slot;
   assign rsp_chan.slot_filled      = out_ff.slot_filled;
   assign rsp_chan.evicted_valid    = out_ff.evicted_valid;
   assign rsp_chan.evicted_block_id = out_ff.evicted_block_id;

   // block id is taken modulo 2^ID_BITS
   assign req_id_wide = gpsc_pkg::ID_WIDE'(req_chan.block_id);
   assign tag_wide    = gpsc_pkg::ID_WIDE'(mem_q_ff.tag);

   // fill target must lie inside the table
   assign si_wide = gpsc_pkg::SLOT_WIDE'(si_ff);
   assign si_ok   = si_wide < gpsc_pkg::SLOT_WIDE'(SLOTS);
   assign si_addr = si_wide[SLOT_W-1:0];

   // saturating count updates
   assign hit_sum   = SUM_W'(mem_q_ff.count) + SUM_W'(w_ff);
   assign hit_count = (hit_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : hit_sum[COUNT_BITS-1:0];
   assign w_sum     = SUM_W'(w_ff);
   assign new_count = (w_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : w_sum[COUNT_BITS-1:0];
   // a count already at zero is evicted without a decrement
   assign dec_count = (mem_q_ff.count != '0) ? mem_q_ff.count - 1'b1 : '0;

   always_comb begin
      new_entry        = '0;
      new_entry.tag    = id_ff;
      new_entry.mode   = gpsc_pkg::MODE_ALLOC;
      new_entry.pinned = 1'b1;
      new_entry.count  = new_count;
   end

   // compare stage of the table scan, folding in the entry just read
   assign cur_match    = q_vld_ff && (mem_q_ff.mode != gpsc_pkg::MODE_EMPTY) &&
                         (mem_q_ff.tag == id_ff);
   assign cur_empty    = q_vld_ff && (mem_q_ff.mode == gpsc_pkg::MODE_EMPTY);
   assign ge_now       = ge_found_ff || (cur_empty && (q_idx_ff >= hand_ff));
   assign ge_idx_now   = ge_found_ff ? ge_idx_ff : q_idx_ff;
   assign any_now      = any_found_ff || cur_empty;
   assign any_idx_now  = any_found_ff ? any_idx_ff : q_idx_ff;
   assign unpinned_now = unpinned_ff || (q_vld_ff && !mem_q_ff.pinned);
   assign chosen       = ge_now ? ge_idx_now : any_idx_now;

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      issue_done_in = issue_done_ff;
      hand_in       = hand_ff;
      clr_rsp_in    = clr_rsp_ff;
      act_in        = act_ff;
      id_in         = id_ff;
      w_in          = w_ff;
      si_in         = si_ff;
      ge_found_in   = ge_found_ff;
      ge_idx_in     = ge_idx_ff;
      any_found_in  = any_found_ff;
      any_idx_in    = any_idx_ff;
      unpinned_in   = unpinned_ff;
      res_in        = res_ff;
      out_in        = out_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rd_en         = 1'b0;
      rd_addr       = scan_ff;
      wr_en         = 1'b0;
      wr_addr       = q_idx_ff;
      wr_data       = mem_q_ff;

      case (state_ff)
         gpsc_pkg::S_CLEAR: begin
            // one entry a cycle back to empty, unpinned, count zero
            wr_en   = 1'b1;
            wr_addr = scan_ff;
            wr_data = '0;
            scan_in = next_slot(scan_ff);
            if (scan_ff == LAST_SLOT) begin
               scan_in    = '0;
               hand_in    = '0;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  res_in        = '0;
                  res_in.status = gpsc_pkg::ST_DONE;
                  state_in      = gpsc_pkg::S_RESP;
               end else begin
                  state_in = gpsc_pkg::S_IDLE;
               end
            end
         end

         gpsc_pkg::S_IDLE: begin
            if (accept) begin
               act_in = gpsc_pkg::gpsc_action_type'(req_chan.action);
               id_in  = req_id_wide[ID_BITS-1:0];
               w_in   = req_chan.ref_weight;
               si_in  = req_chan.slot_index;
               case (gpsc_pkg::gpsc_action_type'(req_chan.action))
                  gpsc_pkg::ACT_REQUEST, gpsc_pkg::ACT_RELEASE: begin
                     scan_in       = '0;
                     issue_done_in = 1'b0;
                     ge_found_in   = 1'b0;
                     any_found_in  = 1'b0;
                     unpinned_in   = 1'b0;
                     state_in      = gpsc_pkg::S_FIND;
                  end
                  gpsc_pkg::ACT_FILL: begin
                     state_in = gpsc_pkg::S_FILL_RD;
                  end
                  gpsc_pkg::ACT_CLEAR: begin
                     scan_in    = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = gpsc_pkg::S_CLEAR;
                  end
                  default: begin
                     state_in = gpsc_pkg::S_IDLE;
                  end
               endcase
            end
         end

         gpsc_pkg::S_FIND: begin
            // issue side: one read a cycle from slot zero upward
            rd_en = !issue_done_ff;
            if (!issue_done_ff) begin
               scan_in = next_slot(scan_ff);
               if (scan_ff == LAST_SLOT) begin
                  issue_done_in = 1'b1;
               end
            end
            // compare side
            if (cur_match) begin
               res_in             = '0;
               res_in.slot        = slot_out(q_idx_ff);
               res_in.slot_filled = (mem_q_ff.mode == gpsc_pkg::MODE_LOADED);
               if (act_ff == gpsc_pkg::ACT_RELEASE) begin
                  wr_en          = 1'b1;
                  wr_data.pinned = 1'b0;
                  res_in.status  = gpsc_pkg::ST_DONE;
               end else if (mem_q_ff.pinned) begin
                  res_in.status = gpsc_pkg::ST_BUSY;
               end else begin
                  wr_en          = 1'b1;
                  wr_data.pinned = 1'b1;
                  wr_data.count  = hit_count;
                  res_in.status  = gpsc_pkg::ST_HIT;
               end
               state_in = gpsc_pkg::S_RESP;
            end else if (q_vld_ff) begin
               ge_found_in  = ge_now;
               ge_idx_in    = ge_idx_now;
               any_found_in = any_now;
               any_idx_in   = any_idx_now;
               unpinned_in  = unpinned_now;
               if (q_idx_ff == LAST_SLOT) begin
                  res_in   = '0;
                  state_in = gpsc_pkg::S_RESP;
                  if (act_ff == gpsc_pkg::ACT_RELEASE) begin
                     res_in.status = gpsc_pkg::ST_NOT_FOUND;
                  end else if (ge_now || any_now) begin
                     // free slot at or after the hand, else the first one
                     wr_en         = 1'b1;
                     wr_addr       = chosen;
                     wr_data       = new_entry;
                     hand_in       = next_slot(chosen);
                     res_in.status = gpsc_pkg::ST_MISS_FREE;
                     res_in.slot   = slot_out(chosen);
                  end else if (unpinned_now) begin
                     scan_in  = hand_ff;
                     state_in = gpsc_pkg::S_SWEEP;
                  end else begin
                     // every slot pinned
                     res_in.status = gpsc_pkg::ST_NONE;
                  end
               end
            end
         end

         gpsc_pkg::S_SWEEP: begin
            // read one slot ahead while the previous one is aged
            rd_en   = 1'b1;
            scan_in = next_slot(scan_ff);
            if (q_vld_ff && !mem_q_ff.pinned) begin
               wr_en = 1'b1;
               if (dec_count == '0) begin
                  wr_data                 = new_entry;
                  hand_in                 = next_slot(q_idx_ff);
                  res_in                  = '0;
                  res_in.status           = gpsc_pkg::ST_MISS_EVICT;
                  res_in.slot             = slot_out(q_idx_ff);
                  res_in.evicted_valid    = 1'b1;
                  res_in.evicted_block_id = tag_wide[gpsc_pkg::ID_W-1:0];
                  state_in                = gpsc_pkg::S_RESP;
               end else begin
                  wr_data.count = dec_count;
               end
            end
         end

         gpsc_pkg::S_FILL_RD: begin
            rd_addr = si_addr;
            if (si_ok) begin
               state_in = gpsc_pkg::S_FILL_CHK;
            end else begin
               res_in        = '0;
               res_in.status = gpsc_pkg::ST_NOT_FOUND;
               res_in.slot   = si_ff;
               state_in      = gpsc_pkg::S_RESP;
            end
         end

         gpsc_pkg::S_FILL_CHK: begin
            res_in      = '0;
            res_in.slot = si_ff;
            if ((mem_q_ff.mode != gpsc_pkg::MODE_EMPTY) && (mem_q_ff.tag == id_ff)) begin
               wr_en              = 1'b1;
               wr_addr            = si_addr;
               wr_data.mode       = gpsc_pkg::MODE_LOADED;
               res_in.status      = gpsc_pkg::ST_DONE;
               res_in.slot_filled = 1'b1;
            end else begin
               res_in.status = gpsc_pkg::ST_NOT_FOUND;
            end
            state_in = gpsc_pkg::S_RESP;
         end

         gpsc_pkg::S_RESP: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = gpsc_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = gpsc_pkg::S_IDLE;
         end
      endcase
   end

   // slot table: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gpsc_pkg::S_CLEAR;
         scan_ff       <= '0;
         issue_done_ff <= 1'b0;
         q_vld_ff      <= 1'b0;
         hand_ff       <= '0;
         clr_rsp_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         issue_done_ff <= issue_done_in;
         q_vld_ff      <= rd_en;
         hand_ff       <= hand_in;
         clr_rsp_ff    <= clr_rsp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      q_idx_ff     <= rd_addr;
      act_ff       <= act_in;
      id_ff        <= id_in;
      w_ff         <= w_in;
      si_ff        <= si_in;
      ge_found_ff  <= ge_found_in;
      ge_idx_ff    <= ge_idx_in;
      any_found_ff <= any_found_in;
      any_idx_ff   <= any_idx_in;
      unpinned_ff  <= unpinned_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
   end

`ifndef ASSERT_OFF
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gpsc_pkg::S_IDLE) |-> !wr_en)
      else $error("table written while idle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != gpsc_pkg::S_IDLE))
      else $error("sequencer stayed idle after an accepted beat");

   a_hand_in_range: assert property (@(posedge clock) disable iff (reset)
      hand_ff <= LAST_SLOT)
      else $error("clock hand beyond the table");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == gpsc_pkg::S_RESP))
      else $error("result beat raised outside the handover state");

   a_sweep_writes_read_slot: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == gpsc_pkg::S_SWEEP) && wr_en) |-> (q_vld_ff && (wr_addr == q_idx_ff)))
      else $error("sweep wrote a slot it did not just read");
`endif

endmodule

// File: bench/gclock_pinned_slot_cache_tb.sv
`timescale 1ns / 1ps
// gclock_pinned_slot_cache_tb: self-checking bench for the gclock pinned slot cache
// keeps its own copy of the slot table to predict every result beat
// needs gpsc_pkg, gpsc_req_if, gpsc_rsp_if and gclock_pinned_slot_cache
module gclock_pinned_slot_cache_tb;
   import gpsc_pkg::*;

   localparam int SLOTS        = 64;
   localparam int COUNT_MAX    = 255;
   localparam int POOL_SIZE    = 72;
   localparam int RANDOM_BEATS = 1400;
   localparam int REPORT_MAX   = 10;
   // worst case per beat: a sweep over saturated counts plus the longest gaps,
   // taken over 1600 beats and then three times over
   localparam longint CYCLE_LIMIT = 64'd1600 * ((COUNT_MAX + 2) * SLOTS + 400) * 3;

   typedef struct packed {
      gpsc_action_type        act;
      logic [ID_W-1:0]        id;
      logic [WEIGHT_W-1:0]    weight;
      logic [INDEX_W-1:0]     index;
   } slot_action_t;

   logic clock;
   logic reset;

   gpsc_req_if req_chan ();
   gpsc_rsp_if rsp_chan ();

   gclock_pinned_slot_cache dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow slot table
   logic [ID_W-1:0] tbl_tag   [SLOTS];
   gpsc_mode_type   tbl_mode  [SLOTS];
   bit              tbl_pin   [SLOTS];
   int unsigned     tbl_count [SLOTS];
   int              clock_hand;
   int              empty_slots;

   slot_action_t    action_q  [$];   // beats waiting for the driver
   gpsc_result_type outcome_q [$];   // predicted results, oldest first

   logic [ID_W-1:0] id_pool [POOL_SIZE];
   int              fail_count  = 0;
   int unsigned     send_gap    = 0;
   int unsigned     recv_stall  = 0;
   bit              calm        = 0;   // no idling on either side while set
   longint          cycle_count = 0;

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned sat_weight(int unsigned a, int unsigned b);
      int unsigned s;
      s = a + b;
      return (s > COUNT_MAX) ? COUNT_MAX : s;
   endfunction

   // slot holding a block, -1 when not cached; tags of empty slots are never read
   function automatic int find_slot(logic [ID_W-1:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (tbl_mode[i] != MODE_EMPTY && tbl_tag[i] == id)
            return i;
      return -1;
   endfunction

   function automatic void claim_slot(int i, logic [ID_W-1:0] id, logic [WEIGHT_W-1:0] w);
      tbl_tag[i]   = id;
      tbl_mode[i]  = MODE_ALLOC;
      tbl_pin[i]   = 1'b1;
      tbl_count[i] = sat_weight(0, w);
      clock_hand   = (i + 1) % SLOTS;
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < SLOTS; i++) begin
         tbl_mode[i]  = MODE_EMPTY;
         tbl_pin[i]   = 1'b0;
         tbl_count[i] = 0;
      end
      clock_hand  = 0;
      empty_slots = SLOTS;
   endfunction

   // request: hit, busy, free slot from the hand, a gclock sweep, or none when all pinned
   function automatic gpsc_result_type place_block(logic [ID_W-1:0] id,
                                                   logic [WEIGHT_W-1:0] w);
      gpsc_result_type r;
      int h;
      int i;
      bit any_unpinned;
      r = '0;
      h = find_slot(id);
      if (h >= 0) begin
         r.slot        = h[INDEX_W-1:0];
         r.slot_filled = (tbl_mode[h] == MODE_LOADED);
         if (tbl_pin[h]) begin
            r.status = ST_BUSY;
            return r;
         end
         tbl_pin[h]   = 1'b1;
         tbl_count[h] = sat_weight(tbl_count[h], w);
         r.status     = ST_HIT;
         return r;
      end
      if (empty_slots > 0) begin
         for (int k = 0; k < SLOTS; k++) begin
            i = (clock_hand + k) % SLOTS;
            if (tbl_mode[i] == MODE_EMPTY) begin
               empty_slots--;
               claim_slot(i, id, w);
               r.status = ST_MISS_FREE;
               r.slot   = i[INDEX_W-1:0];
               return r;
            end
         end
         empty_slots = 0;   // stale count, go on with a sweep
      end
      any_unpinned = 1'b0;
      for (int k = 0; k < SLOTS; k++)
         if (!tbl_pin[k])
            any_unpinned = 1'b1;
      r.status = ST_NONE;
      if (!any_unpinned)
         return r;
      for (int k = 0; k < (COUNT_MAX + 2) * SLOTS; k++) begin
         i = (clock_hand + k) % SLOTS;
         if (!tbl_pin[i]) begin
            // a count already at zero is taken without a decrement
            if (tbl_count[i] > 0)
               tbl_count[i]--;
            if (tbl_count[i] == 0) begin
               r.status           = ST_MISS_EVICT;
               r.slot             = i[INDEX_W-1:0];
               r.evicted_valid    = 1'b1;
               r.evicted_block_id = tbl_tag[i];
               claim_slot(i, id, w);
               return r;
            end
         end
      end
      return r;
   endfunction

   function automatic gpsc_result_type resolve_action(slot_action_t a);
      gpsc_result_type r;
      int h;
      r = '0;
      case (a.act)
         ACT_REQUEST: begin
            r = place_block(a.id, a.weight);
         end
         ACT_RELEASE: begin
            h = find_slot(a.id);
            if (h < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               tbl_pin[h]    = 1'b0;
               r.status      = ST_DONE;
               r.slot        = h[INDEX_W-1:0];
               r.slot_filled = (tbl_mode[h] == MODE_LOADED);
            end
         end
         ACT_FILL: begin
            r.slot = a.index;
            if (tbl_mode[a.index] != MODE_EMPTY && tbl_tag[a.index] == a.id) begin
               tbl_mode[a.index] = MODE_LOADED;
               r.status          = ST_DONE;
               r.slot_filled     = 1'b1;
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
         default: begin
            wipe_table();
            r.status = ST_DONE;
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // idle length: mostly none or short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // small weights keep sweeps short; the full range still shows up
   function automatic logic [WEIGHT_W-1:0] pick_weight();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(0, 3);
      else if (r < 95)
         return $urandom_range(0, 31);
      return $urandom_range(0, 255);
   endfunction

   // the generator runs on falling edges, away from the driver
   task automatic push_beat(gpsc_action_type act, logic [ID_W-1:0] id,
                            logic [WEIGHT_W-1:0] w, logic [INDEX_W-1:0] idx);
      slot_action_t a;
      a.act    = act;
      a.id     = id;
      a.weight = w;
      a.index  = idx;
      while (action_q.size() >= 2)
         @(negedge clock);
      action_q.push_back(a);
   endtask

   task automatic wait_idle();
      while (action_q.size() != 0 || req_chan.valid || outcome_q.size() != 0)
         @(negedge clock);
   endtask

   // fill the whole table with pinned blocks, hit the all-pinned case,
   // then free a few slots and force evictions, some on zero counts
   task automatic pin_everything();
      logic [ID_W-1:0] held [SLOTS];
      logic [ID_W-1:0] id;
      int j;
      push_beat(ACT_CLEAR, 0, 0, 0);
      for (int i = 0; i < SLOTS; i++) begin
         held[i] = $urandom();
         push_beat(ACT_REQUEST, held[i], (i % 8 == 0) ? 8'd0 : pick_weight(), $urandom());
      end
      for (int i = 0; i < 4; i++)
         push_beat(ACT_FILL, held[i], $urandom(), i);
      push_beat(ACT_REQUEST, held[2], pick_weight(), 0);   // busy on a loaded slot
      for (int i = 0; i < 2; i++) begin
         id = $urandom();
         push_beat(ACT_REQUEST, id, pick_weight(), 0);     // nothing unpinned
      end
      for (int i = 0; i < 10; i++) begin
         j = $urandom_range(0, SLOTS - 1);
         push_beat(ACT_RELEASE, held[j], $urandom(), $urandom());
      end
      push_beat(ACT_RELEASE, held[0], 0, 0);               // a zero-count slot
      for (int i = 0; i < 12; i++) begin
         id = $urandom();
         push_beat(ACT_REQUEST, id, pick_weight(), $urandom());
         if (i % 3 == 0)
            push_beat(ACT_RELEASE, id, 0, 0);
      end
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : request_driver
      slot_action_t beat;
      bit fire;
      fire = req_chan.valid && req_chan.ready;
      // predict at the edge that takes the beat
      if (fire) begin
         beat.act    = gpsc_action_type'(req_chan.action);
         beat.id     = req_chan.block_id;
         beat.weight = req_chan.ref_weight;
         beat.index  = req_chan.slot_index;
         outcome_q.push_back(resolve_action(beat));
      end
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
      end else if (!req_chan.valid || fire) begin
         if (send_gap != 0) begin
            req_chan.valid <= 1'b0;
            send_gap       <= send_gap - 1;
         end else if (action_q.size() != 0) begin
            beat = action_q.pop_front();
            req_chan.action     <= beat.act;
            req_chan.block_id   <= beat.id;
            req_chan.ref_weight <= beat.weight;
            req_chan.slot_index <= beat.index;
            req_chan.valid      <= 1'b1;
            send_gap            <= pick_gap();   // idle after this beat is taken
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   function automatic void flag_failure(string what, gpsc_result_type want,
                                        gpsc_result_type seen);
      fail_count++;
      if (fail_count <= REPORT_MAX)
         $display("%s at cycle %0d: expected status %0d slot %0d filled %0b ",
                  what, cycle_count, want.status, want.slot, want.slot_filled,
                  "evicted %0b id %h, got status %0d slot %0d filled %0b ",
                  want.evicted_valid, want.evicted_block_id,
                  seen.status, seen.slot, seen.slot_filled,
                  "evicted %0b id %h", seen.evicted_valid, seen.evicted_block_id);
   endfunction

   always @(posedge clock) begin : result_monitor
      gpsc_result_type seen;
      gpsc_result_type want;
      int unsigned stall;
      bit fire;
      fire = rsp_chan.valid && rsp_chan.ready;
      if (fire) begin
         seen.status           = gpsc_status_type'(rsp_chan.status);
         seen.slot             = rsp_chan.slot;
         seen.slot_filled      = rsp_chan.slot_filled;
         seen.evicted_valid    = rsp_chan.evicted_valid;
         seen.evicted_block_id = rsp_chan.evicted_block_id;
         if (outcome_q.size() == 0) begin
            flag_failure("result with nothing expected", '0, seen);
         end else begin
            want = outcome_q.pop_front();
            if (seen.status !== want.status || seen.slot !== want.slot ||
                seen.slot_filled !== want.slot_filled ||
                seen.evicted_valid !== want.evicted_valid ||
                seen.evicted_block_id !== want.evicted_block_id)
               flag_failure("mismatch", want, seen);
         end
      end
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_stall     <= 0;
      end else if (fire) begin
         stall = pick_gap();
         rsp_chan.ready <= (stall == 0);
         recv_stall     <= (stall == 0) ? 0 : stall - 1;
      end else if (recv_stall != 0) begin
         rsp_chan.ready <= 1'b0;
         recv_stall     <= recv_stall - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence

   initial begin : stimulus
      logic [ID_W-1:0]    id;
      logic [INDEX_W-1:0] idx;
      int                 r;
      int                 h;
      clock               = 1'b0;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.action     = ACT_REQUEST;
      req_chan.block_id   = '0;
      req_chan.ref_weight = '0;
      req_chan.slot_index = '0;
      rsp_chan.ready      = 1'b0;
      wipe_table();
      for (int i = 0; i < POOL_SIZE; i++)
         id_pool[i] = $urandom();
      id_pool[0] = '0;
      id_pool[1] = '1;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, every action, the named corner cases
      push_beat(ACT_CLEAR,   24'h000000, 8'd0,   6'd0);
      push_beat(ACT_REQUEST, 24'h000000, 8'd255, 6'd63);   // miss into slot 0
      push_beat(ACT_REQUEST, 24'h000000, 8'd7,   6'd0);    // busy, not loaded
      push_beat(ACT_FILL,    24'h000000, 8'd0,   6'd0);    // fill done
      push_beat(ACT_FILL,    24'hFFFFFF, 8'd255, 6'd0);    // tag mismatch
      push_beat(ACT_FILL,    24'h000000, 8'd0,   6'd63);   // empty slot
      push_beat(ACT_RELEASE, 24'h000000, 8'd0,   6'd0);    // loaded release
      push_beat(ACT_REQUEST, 24'h000000, 8'd255, 6'd0);    // hit, count saturates
      push_beat(ACT_REQUEST, 24'h000000, 8'd1,   6'd0);    // busy on loaded slot
      push_beat(ACT_RELEASE, 24'hFFFFFF, 8'd0,   6'd0);    // release of uncached block
      push_beat(ACT_REQUEST, 24'hFFFFFF, 8'd0,   6'd0);    // miss, zero weight
      push_beat(ACT_FILL,    24'hFFFFFF, 8'd0,   6'd1);
      push_beat(ACT_RELEASE, 24'hFFFFFF, 8'd0,   6'd0);
      push_beat(ACT_REQUEST, 24'hA5C396, 8'h80,  6'h2A);
      push_beat(ACT_FILL,    24'hA5C396, 8'h7F,  6'd1);    // right id, wrong slot
      push_beat(ACT_RELEASE, 24'hA5C396, 8'd0,   6'd0);
      push_beat(ACT_RELEASE, 24'h000000, 8'd0,   6'd0);
      push_beat(ACT_REQUEST, 24'h5A3C69, 8'h55,  6'h15);
      push_beat(ACT_CLEAR,   24'hFFFFFF, 8'd255, 6'd63);
      push_beat(ACT_RELEASE, 24'h000000, 8'd0,   6'd0);    // gone after clear
      push_beat(ACT_FILL,    24'h000000, 8'd0,   6'd0);    // slot emptied by clear

      // hold the sender until every outcome has come back
      wait_idle();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         calm = (n >= 600 && n < 750);
         if (n == 300 || n == 1000)
            pin_everything();
         // slow churn of the working set so evicted ids vary
         if ($urandom_range(0, 99) < 3)
            id_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom();
         if ($urandom_range(0, 19) == 0)
            id = $urandom();
         else
            id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
         r = $urandom_range(0, 99);
         if (r < 48) begin
            push_beat(ACT_REQUEST, id, pick_weight(), $urandom());
         end else if (r < 80) begin
            push_beat(ACT_RELEASE, id, $urandom(), $urandom());
         end else if (r < 97) begin
            // mostly aim at the slot the block sits in
            h = find_slot(id);
            if (h >= 0 && $urandom_range(0, 9) != 0)
               idx = h[INDEX_W-1:0];
            else
               idx = $urandom();
            push_beat(ACT_FILL, id, $urandom(), idx);
         end else begin
            push_beat(gpsc_action_type'($urandom_range(0, 3)), $urandom(), $urandom(),
                      $urandom());
         end
      end
      calm = 0;

      wait_idle();
      // room for a stray beat after the last one
      repeat (2 * SLOTS + 8) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
sv/gpsc_pkg.sv
sv/gpsc_req_if.sv
sv/gpsc_rsp_if.sv
sv/gclock_pinned_slot_cache.sv
bench/gclock_pinned_slot_cache_tb.sv
